// File: src/sdfe_pkg.sv
// Shared types and constants of the SSE data field extractor.
// No dependencies; imported by the parser, the result queue and the top level.
package sdfe_pkg;

	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;

	localparam int PREFIX_LEN = 5;
	localparam int PM_W       = $clog2(PREFIX_LEN + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		PH_MATCH = 4'b0001,
		PH_COLON = 4'b0010,
		PH_DATA  = 4'b0100,
		PH_SKIP  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} result_t;

	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

	typedef struct packed {
		logic held_valid;
		logic newline_pending;
	} parse_stat_t;

	function automatic logic [7:0] prefix_char(input logic [PM_W-1:0] idx);
		logic [7:0] ch;
		case (idx)
			PM_W'(0): ch = CH_D;
			PM_W'(1): ch = CH_A;
			PM_W'(2): ch = CH_T;
			PM_W'(3): ch = CH_A;
			PM_W'(4): ch = CH_COLON;
			default:  ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// File: src/sdfe_parser.sv
// Line and event parser: tracks prefix match, pairing of line feeds and the held byte.
// Depends on sdfe_pkg; produces up to two result words per accepted byte.
module sdfe_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           body_byte,
	input  logic                 end_of_body,
	output sdfe_pkg::push_t      push,
	output sdfe_pkg::parse_stat_t stat
);
	import sdfe_pkg::*;

	logic            newline_pending_q;
	phase_t          phase_q;
	logic [PM_W-1:0] matched_q;
	logic [7:0]      held_byte_q;
	logic            held_valid_q;

	logic            is_lf, is_cr, boundary, payload;
	logic            emit0, emit1, mid_valid;
	logic [7:0]      mid_byte;
	phase_t          phase_d;
	logic [PM_W-1:0] matched_d;
	logic [PM_W-1:0] matched_inc;

	always_comb begin
		is_lf       = (body_byte == CH_LF);
		is_cr       = (body_byte == CH_CR);
		boundary    = is_lf && newline_pending_q;
		payload     = !is_lf && !is_cr &&
			(((phase_q == PH_COLON) && (body_byte != CH_SPACE)) || (phase_q == PH_DATA));
		matched_inc = matched_q + PM_W'(1);

		phase_d   = phase_q;
		matched_d = matched_q;
		if (is_lf || is_cr) begin
			phase_d   = PH_MATCH;
			matched_d = '0;
		end else begin
			case (phase_q)
				PH_MATCH: begin
					if ((matched_q < PM_W'(PREFIX_LEN)) && (body_byte == prefix_char(matched_q))) begin
						matched_d = matched_inc;
						if (matched_inc == PM_W'(PREFIX_LEN))
							phase_d = PH_COLON;
					end else begin
						phase_d = PH_SKIP;
					end
				end
				PH_COLON: phase_d = PH_DATA;
				PH_DATA:  phase_d = PH_DATA;
				default:  phase_d = PH_SKIP;
			endcase
		end

		emit0     = held_valid_q && (boundary || payload);
		mid_valid = payload || (held_valid_q && !boundary);
		mid_byte  = payload ? body_byte : held_byte_q;
		emit1     = end_of_body && mid_valid;

		push.v0 = accept && (emit0 || emit1);
		push.v1 = accept && emit0 && emit1;
		if (emit0) begin
			push.r0 = '{data_byte: held_byte_q, last: boundary};
		end else begin
			push.r0 = '{data_byte: mid_byte, last: 1'b1};
		end
		push.r1 = '{data_byte: mid_byte, last: 1'b1};

		stat.held_valid      = held_valid_q;
		stat.newline_pending = newline_pending_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newline_pending_q <= 1'b0;
			phase_q           <= PH_MATCH;
			matched_q         <= '0;
			held_valid_q      <= 1'b0;
		end else if (accept) begin
			if (end_of_body) begin
				newline_pending_q <= 1'b0;
				phase_q           <= PH_MATCH;
				matched_q         <= '0;
				held_valid_q      <= 1'b0;
			end else begin
				newline_pending_q <= is_lf && !newline_pending_q;
				phase_q           <= phase_d;
				matched_q         <= matched_d;
				held_valid_q      <= mid_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			held_byte_q <= mid_byte;
	end

endmodule

// File: src/sdfe_queue.sv
// Result queue: takes up to two words per cycle, hands out one per cycle while pop is high.
// Depends on sdfe_pkg; separates the parser from the output handshake.
module sdfe_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sdfe_pkg::push_t           push,
	input  logic                      pop,
	output sdfe_pkg::result_t         head,
	output logic                      not_empty,
	output logic [sdfe_pkg::LVL_W-1:0] level
);
	import sdfe_pkg::*;

	result_t          mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic [LVL_W-1:0] n_push;

	assign n_push    = LVL_W'(push.v0) + LVL_W'(push.v1);
	assign head      = mem[rd_ptr_q];
	assign not_empty = (level_q != '0);
	assign level     = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			level_q <= level_q + n_push - LVL_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.v0)
			mem[wr_ptr_q] <= push.r0;
		if (push.v1)
			mem[wr_ptr_q + PTR_W'(1)] <= push.r1;
	end

endmodule

// File: src/sse_data_field_extractor.sv
// Top level of the SSE data field extractor: parser followed by a result queue.
// Depends on sdfe_pkg, sdfe_parser and sdfe_queue.
//
//   channel  | handshake                | words
//   body in  | body_valid / body_ready  | body_byte, end_of_body
//   data out | data_valid / data_ready  | data_byte, last
//
// One body byte per cycle while body_ready is high; a payload byte is held until the
// next payload byte, a blank-line boundary or end_of_body releases it, and a released
// word is written into the result queue when the releasing byte is taken. The four-word
// result queue sets the stall point: body_ready drops once more than two words wait.
// Reset leaves the block at the start of a fresh body with the queue empty.
module sse_data_field_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       body_valid,
	output logic       body_ready,
	input  logic [7:0] body_byte,
	input  logic       end_of_body,
	output logic       data_valid,
	input  logic       data_ready,
	output logic [7:0] data_byte,
	output logic       last
);
	import sdfe_pkg::*;

	logic             accept;
	push_t            push;
	parse_stat_t      stat;
	result_t          head;
	logic [LVL_W-1:0] level;

	assign body_ready = (level <= LVL_W'(QUEUE_DEPTH - 2));
	assign accept     = body_valid && body_ready;

	sdfe_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.body_byte   (body_byte),
		.end_of_body (end_of_body),
		.push        (push),
		.stat        (stat)
	);

	sdfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (data_valid && data_ready),
		.head      (head),
		.not_empty (data_valid),
		.level     (level)
	);

	assign data_byte = head.data_byte;
	assign last      = head.last;

`ifndef SYNTH
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= LVL_W'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0 && push.r1.last)
		else $error("second word without first or not final");

	a_eob_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_body |=> !stat.held_valid && !stat.newline_pending)
		else $error("state not cleared after end of body");

	a_no_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |-> !push.v0)
		else $error("word pushed without an accepted byte");
`endif

endmodule
